// ===== design/cwpam_pkg.sv =====
// ----------------------------------------------------------------------------
// cwpam_pkg
// Types, codes and constants shared by the packed weight image address mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cwpam_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] REG_INPUT_CHANNELS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OUTPUT_KERNELS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KERNEL_WIDTH   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KERNEL_HEIGHT  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_QUANTIZED_MODE = 3'd4;

  localparam logic [9:0]  TABLE_BYTES = 10'd512;
  localparam logic [30:0] LIMIT31     = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_TABLE  = 2'd2
  } op_e;

  typedef struct packed {
    logic [12:0] input_channels;
    logic [12:0] output_kernels;
    logic [2:0]  kernel_width;
    logic [2:0]  kernel_height;
    logic        quantized_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] out_channel;
    logic [11:0] in_channel;
    logic [2:0]  tap_row;
    logic [2:0]  tap_col;
    logic [7:0]  table_slot;
    logic [15:0] element_value;
  } item_t;

  typedef struct packed {
    op_e         kind;
    logic        item_ok;
    logic        cfg_ok;
    logic        quant;
    logic [20:0] nk;
    logic [10:0] ngroups;
    logic [16:0] ng_prod;
    logic [8:0]  grp;
    logic [5:0]  tap_sel;
    logic [5:0]  ntaps;
    logic [9:0]  cp;
    logic [2:0]  lane;
    logic [6:0]  tile_pos;
    logic [7:0]  slot;
    logic [15:0] value;
  } idx_t;

  typedef struct packed {
    op_e         kind;
    logic        item_ok;
    logic        cfg_ok;
    logic        quant;
    logic [27:0] section;
    logic [27:0] gbase;
    logic [16:0] grp_off;
    logic [5:0]  tap_sel;
    logic [5:0]  ntaps;
    logic [7:0]  slot;
    logic [15:0] value;
  } lay_t;

  typedef struct packed {
    op_e         kind;
    logic        item_ok;
    logic        cfg_ok;
    logic        quant;
    logic [33:0] tap_off;
    logic [33:0] span;
    logic [27:0] gbase;
    logic [16:0] grp_off;
    logic [7:0]  slot;
    logic [15:0] value;
  } scl_t;

  typedef struct packed {
    logic [30:0] dest_offset;
    logic [15:0] value_out;
    logic [1:0]  byte_count;
    logic        in_range;
    logic [30:0] image_size;
  } res_t;

  // tile cell of a channel: row 11 - 3*(t>>1) - v/3, column 3*(t&1) + v%3
  function automatic logic [6:0] cell_index(logic [5:0] ch);
    logic [1:0] pair;
    logic [1:0] vdiv;
    logic [1:0] vmod;
    logic [3:0] row;
    logic [2:0] col;
    pair = ch[2:1];
    case (ch[5:3])
      3'd0: begin vdiv = 2'd0; vmod = 2'd0; end
      3'd1: begin vdiv = 2'd0; vmod = 2'd1; end
      3'd2: begin vdiv = 2'd0; vmod = 2'd2; end
      3'd3: begin vdiv = 2'd1; vmod = 2'd0; end
      3'd4: begin vdiv = 2'd1; vmod = 2'd1; end
      3'd5: begin vdiv = 2'd1; vmod = 2'd2; end
      3'd6: begin vdiv = 2'd2; vmod = 2'd0; end
      default: begin vdiv = 2'd2; vmod = 2'd1; end
    endcase
    row = 4'd11 - (4'({pair, 1'b0}) + 4'(pair)) - 4'(vdiv);
    col = ch[0] ? (3'd3 + 3'(vmod)) : 3'(vmod);
    return 7'({row, 2'b00}) + 7'({row, 1'b0}) + 7'(col);
  endfunction

endpackage

`default_nettype wire

// ===== design/cwpam_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cwpam_cfg_regs
// Layer configuration registers and their range check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwpam_cfg_regs #(
  parameter int MAX_CHANNELS = 4096,
  parameter int MAX_KERNELS  = 4096,
  parameter int MAX_TAP      = 7
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cwpam_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cwpam_pkg::CfgDataW-1:0] cfg_wdata_i,
  output cwpam_pkg::cfg_t                    cfg_o,
  output logic                               range_ok_o
);

  cwpam_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_channels <= 13'd1;
      cfg_q.output_kernels <= 13'd1;
      cfg_q.kernel_width   <= 3'd1;
      cfg_q.kernel_height  <= 3'd1;
      cfg_q.quantized_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cwpam_pkg::REG_INPUT_CHANNELS: cfg_q.input_channels <= cfg_wdata_i;
        cwpam_pkg::REG_OUTPUT_KERNELS: cfg_q.output_kernels <= cfg_wdata_i;
        cwpam_pkg::REG_KERNEL_WIDTH:   cfg_q.kernel_width   <= cfg_wdata_i[2:0];
        cwpam_pkg::REG_KERNEL_HEIGHT:  cfg_q.kernel_height  <= cfg_wdata_i[2:0];
        cwpam_pkg::REG_QUANTIZED_MODE: cfg_q.quantized_mode <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

  assign range_ok_o =
      (cfg_q.input_channels != 13'd0) && (32'(cfg_q.input_channels) <= 32'(MAX_CHANNELS)) &&
      (cfg_q.output_kernels != 13'd0) && (32'(cfg_q.output_kernels) <= 32'(MAX_KERNELS)) &&
      (cfg_q.kernel_width != 3'd0)    && (32'(cfg_q.kernel_width) <= 32'(MAX_TAP)) &&
      (cfg_q.kernel_height != 3'd0)   && (32'(cfg_q.kernel_height) <= 32'(MAX_TAP));

endmodule

`default_nettype wire

// ===== design/cwpam_index.sv =====
// ----------------------------------------------------------------------------
// cwpam_index
// First stage: item decode, bound checks, chunk and group counts, tap index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwpam_index (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cwpam_pkg::cfg_t  cfg_i,
  input  wire logic             range_ok_i,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire cwpam_pkg::item_t data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output cwpam_pkg::idx_t       data_o
);

  logic            valid_q;
  cwpam_pkg::idx_t data_q;
  cwpam_pkg::idx_t data_d;

  logic [13:0] nch_sum;
  logic [13:0] ngr_sum;
  logic [7:0]  nchunks;
  logic [11:0] gfirst;
  logic [12:0] krem;
  logic [3:0]  gsize;
  logic [5:0]  tapidx;
  logic [5:0]  ntaps;
  logic        oc_ok;
  logic        wt_ok;

  always_comb begin
    nch_sum = 14'(cfg_i.input_channels) + 14'd63;
    ngr_sum = 14'(cfg_i.output_kernels) + 14'd7;
    nchunks = nch_sum[13:6];
    gfirst  = {data_i.out_channel[11:3], 3'b000};
    krem    = cfg_i.output_kernels - 13'(gfirst);
    if (cfg_i.output_kernels > 13'(gfirst)) begin
      gsize = (krem >= 13'd8) ? 4'd8 : 4'(krem);
    end else begin
      gsize = 4'd0;
    end
    tapidx = 6'(data_i.tap_row) * 6'(cfg_i.kernel_width) + 6'(data_i.tap_col);
    ntaps  = 6'(cfg_i.kernel_width) * 6'(cfg_i.kernel_height);
    oc_ok  = 13'(data_i.out_channel) < cfg_i.output_kernels;
    wt_ok  = oc_ok && (13'(data_i.in_channel) < cfg_i.input_channels) &&
             (data_i.tap_row < cfg_i.kernel_height) && (data_i.tap_col < cfg_i.kernel_width);

    data_d.cfg_ok   = range_ok_i;
    data_d.quant    = cfg_i.quantized_mode;
    data_d.nk       = 21'(nchunks) * 21'(cfg_i.output_kernels);
    data_d.ngroups  = ngr_sum[13:3];
    data_d.ng_prod  = 17'(nchunks) * 17'(data_i.out_channel[11:3]);
    data_d.grp      = data_i.out_channel[11:3];
    data_d.ntaps    = ntaps;
    data_d.cp       = 10'(data_i.in_channel[11:6]) * 10'(gsize);
    data_d.lane     = data_i.out_channel[2:0];
    data_d.tile_pos = cwpam_pkg::cell_index(data_i.in_channel[5:0]);
    data_d.slot     = data_i.table_slot;
    data_d.value    = data_i.element_value;
    data_d.tap_sel  = tapidx;

    unique case (data_i.operation)
      cwpam_pkg::OP_WEIGHT: begin
        data_d.kind    = cwpam_pkg::OP_WEIGHT;
        data_d.item_ok = wt_ok;
      end
      cwpam_pkg::OP_BIAS: begin
        data_d.kind    = cwpam_pkg::OP_BIAS;
        data_d.item_ok = oc_ok;
        data_d.tap_sel = ntaps - 6'd1;
      end
      cwpam_pkg::OP_TABLE: begin
        data_d.kind    = cwpam_pkg::OP_TABLE;
        data_d.item_ok = cfg_i.quantized_mode;
      end
      default: begin
        data_d.kind    = cwpam_pkg::OP_WEIGHT;
        data_d.item_ok = 1'b0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== design/cwpam_layout.sv =====
// ----------------------------------------------------------------------------
// cwpam_layout
// Second stage: section size, group base and offset inside the group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwpam_layout (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire cwpam_pkg::idx_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output cwpam_pkg::lay_t      data_o
);

  logic            valid_q;
  cwpam_pkg::lay_t data_q;
  cwpam_pkg::lay_t data_d;

  logic [23:0] nk9;
  logic [27:0] nkt;
  logic [27:0] sec_sum;
  logic [19:0] ng9;
  logic [27:0] gtile;
  logic [9:0]  pos;
  logic [12:0] pos9;
  logic [16:0] ptile;
  logic [7:0]  cellb;

  always_comb begin
    // tile bytes are 9 * 8 (quantized) or 9 * 16
    nk9     = {data_i.nk, 3'b000} + 24'(data_i.nk);
    nkt     = data_i.quant ? 28'({nk9, 3'b000}) : {nk9, 4'b0000};
    sec_sum = 28'({data_i.ngroups, 4'b0000}) + nkt + 28'd15;
    ng9     = {data_i.ng_prod, 3'b000} + 20'(data_i.ng_prod);
    gtile   = data_i.quant ? 28'({ng9, 6'b000000}) : 28'({ng9, 7'b0000000});
    pos     = data_i.cp + 10'(data_i.lane);
    pos9    = {pos, 3'b000} + 13'(pos);
    ptile   = data_i.quant ? 17'({pos9, 3'b000}) : {pos9, 4'b0000};
    cellb   = data_i.quant ? 8'(data_i.tile_pos) : {data_i.tile_pos, 1'b0};

    data_d.kind    = data_i.kind;
    data_d.item_ok = data_i.item_ok;
    data_d.cfg_ok  = data_i.cfg_ok;
    data_d.quant   = data_i.quant;
    data_d.section = {sec_sum[27:4], 4'b0000};
    data_d.gbase   = gtile + 28'({data_i.grp, 4'b0000});
    data_d.grp_off = (data_i.kind == cwpam_pkg::OP_BIAS) ? 17'({data_i.lane, 1'b0})
                                                         : 17'd16 + ptile + 17'(cellb);
    data_d.tap_sel = data_i.tap_sel;
    data_d.ntaps   = data_i.ntaps;
    data_d.slot    = data_i.slot;
    data_d.value   = data_i.value;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== design/cwpam_scale.sv =====
// ----------------------------------------------------------------------------
// cwpam_scale
// Third stage: tap section offset and whole tap span multiplies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwpam_scale (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire cwpam_pkg::lay_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output cwpam_pkg::scl_t      data_o
);

  logic            valid_q;
  cwpam_pkg::scl_t data_q;
  cwpam_pkg::scl_t data_d;

  always_comb begin
    data_d.kind    = data_i.kind;
    data_d.item_ok = data_i.item_ok;
    data_d.cfg_ok  = data_i.cfg_ok;
    data_d.quant   = data_i.quant;
    data_d.tap_off = 34'(data_i.tap_sel) * 34'(data_i.section);
    data_d.span    = 34'(data_i.ntaps) * 34'(data_i.section);
    data_d.gbase   = data_i.gbase;
    data_d.grp_off = data_i.grp_off;
    data_d.slot    = data_i.slot;
    data_d.value   = data_i.value;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== design/cwpam_result.sv =====
// ----------------------------------------------------------------------------
// cwpam_result
// Last stage: image size check, final offset sum and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwpam_result (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire cwpam_pkg::scl_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output cwpam_pkg::res_t      data_o
);

  logic            valid_q;
  cwpam_pkg::res_t data_q;
  cwpam_pkg::res_t data_d;

  logic [34:0] prefix;
  logic [34:0] size;
  logic [34:0] off;
  logic        size_ok;
  logic        elem_ok;
  logic        qweight;

  always_comb begin
    prefix  = data_i.quant ? 35'(cwpam_pkg::TABLE_BYTES) : 35'd0;
    size    = prefix + 35'(data_i.span);
    off     = prefix + 35'(data_i.tap_off) + 35'(data_i.gbase) + 35'(data_i.grp_off);
    size_ok = data_i.cfg_ok && (size <= 35'(cwpam_pkg::LIMIT31));
    elem_ok = size_ok && data_i.item_ok;
    qweight = data_i.quant && (data_i.kind == cwpam_pkg::OP_WEIGHT);

    data_d.image_size  = size_ok ? size[30:0] : 31'd0;
    data_d.in_range    = elem_ok;
    data_d.dest_offset = 31'd0;
    data_d.value_out   = 16'd0;
    data_d.byte_count  = 2'd0;
    if (elem_ok) begin
      data_d.dest_offset = (data_i.kind == cwpam_pkg::OP_TABLE) ? 31'({data_i.slot, 1'b0})
                                                                : off[30:0];
      data_d.value_out   = qweight ? {8'd0, data_i.value[7:0]} : data_i.value;
      data_d.byte_count  = qweight ? 2'd1 : 2'd2;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== design/conv_weight_pack_address_mapper.sv =====
// ----------------------------------------------------------------------------
// conv_weight_pack_address_mapper
// Byte offset, byte count and image size of each element of a packed
// convolution weight image.
//
//   channel   direction  handshake                  payload
//   item      in         in_valid_i / in_stall_o    operation_i .. element_value_i
//   result    out        out_valid_o / out_stall_i  dest_offset_o .. image_size_o
//   config    in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// one transfer per cycle in, one result per cycle out while out_stall_i is low,
// through index, layout, multiply and output register stages
// no clearing pass after reset; config registers come up at 1,1,1,1,0
// a stall holds the output register, bubbles ahead of it still fill
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module conv_weight_pack_address_mapper #(
  parameter int MAX_CHANNELS = 4096,
  parameter int MAX_KERNELS  = 4096,
  parameter int MAX_TAP      = 7
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [11:0]                   out_channel_i,
  input  wire logic [11:0]                   in_channel_i,
  input  wire logic [2:0]                    tap_row_i,
  input  wire logic [2:0]                    tap_col_i,
  input  wire logic [7:0]                    table_slot_i,
  input  wire logic [15:0]                   element_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [30:0]                        dest_offset_o,
  output logic [15:0]                        value_out_o,
  output logic [1:0]                         byte_count_o,
  output logic                               in_range_o,
  output logic [30:0]                        image_size_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [cwpam_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cwpam_pkg::CfgDataW-1:0] cfg_wdata_i
);

  cwpam_pkg::cfg_t  cfg;
  logic             range_ok;
  cwpam_pkg::item_t item;
  cwpam_pkg::idx_t  idx_data;
  cwpam_pkg::lay_t  lay_data;
  cwpam_pkg::scl_t  scl_data;
  cwpam_pkg::res_t  res_data;
  logic             idx_ready;
  logic             idx_valid;
  logic             lay_ready;
  logic             lay_valid;
  logic             scl_ready;
  logic             scl_valid;
  logic             res_ready;

  assign item.operation     = operation_i;
  assign item.out_channel   = out_channel_i;
  assign item.in_channel    = in_channel_i;
  assign item.tap_row       = tap_row_i;
  assign item.tap_col       = tap_col_i;
  assign item.table_slot    = table_slot_i;
  assign item.element_value = element_value_i;

  cwpam_cfg_regs #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_KERNELS (MAX_KERNELS),
    .MAX_TAP     (MAX_TAP)
  ) u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg),
    .range_ok_o (range_ok)
  );

  cwpam_index u_index (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .range_ok_i(range_ok),
    .valid_i   (in_valid_i),
    .ready_o   (idx_ready),
    .data_i    (item),
    .valid_o   (idx_valid),
    .ready_i   (lay_ready),
    .data_o    (idx_data)
  );

  cwpam_layout u_layout (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(idx_valid),
    .ready_o(lay_ready),
    .data_i (idx_data),
    .valid_o(lay_valid),
    .ready_i(scl_ready),
    .data_o (lay_data)
  );

  cwpam_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(lay_valid),
    .ready_o(scl_ready),
    .data_i (lay_data),
    .valid_o(scl_valid),
    .ready_i(res_ready),
    .data_o (scl_data)
  );

  cwpam_result u_result (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(scl_valid),
    .ready_o(res_ready),
    .data_i (scl_data),
    .valid_o(out_valid_o),
    .ready_i(!out_stall_i),
    .data_o (res_data)
  );

  assign in_stall_o    = !idx_ready;
  assign dest_offset_o = res_data.dest_offset;
  assign value_out_o   = res_data.value_out;
  assign byte_count_o  = res_data.byte_count;
  assign in_range_o    = res_data.in_range;
  assign image_size_o  = res_data.image_size;

endmodule

`default_nettype wire

// ===== design/cwpam_checker.sv =====
// ----------------------------------------------------------------------------
// cwpam_checker
// Port level checks of the packed weight image address mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cwpam_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [30:0] dest_offset_o,
  input wire logic [15:0] value_out_o,
  input wire logic [1:0]  byte_count_o,
  input wire logic        in_range_o,
  input wire logic [30:0] image_size_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(dest_offset_o) && $stable(value_out_o) &&
      $stable(byte_count_o) && $stable(in_range_o) && $stable(image_size_o))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> dest_offset_o == 31'd0 && value_out_o == 16'd0 &&
      byte_count_o == 2'd0)
    else $error("rejected item carries data");

  a_accept_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_range_o |-> byte_count_o != 2'd0 && image_size_o != 31'd0 &&
      (byte_count_o == 2'd2 || dest_offset_o < image_size_o))
    else $error("accepted item without image");

  a_byte_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_count_o == 2'd1 |-> value_out_o[15:8] == 8'd0)
    else $error("single byte result with high bits set");

endmodule

bind conv_weight_pack_address_mapper cwpam_checker u_checker (.*);

`default_nettype wire
